// ----- rtl/isf_pkg.sv -----
package isf_pkg;

  localparam int unsigned MaxParams = 26;
  localparam logic [7:0] MAX_PARAMS = 8'(MaxParams);

  localparam logic [7:0] SYNC_STD = 8'hFF;
  localparam logic [7:0] SYNC_ALT = 8'hFE;
  localparam logic [7:0] TRAILER_ALT = 8'hFA;
  localparam logic [7:0] LEN_OVERHEAD = 8'd2;
  localparam logic [7:0] ERR_BYTE = 8'h00;

  // Frame format register values
  localparam logic FMT_STD = 1'b0;
  localparam logic FMT_ALT = 1'b1;

  localparam int unsigned QDepth = 4;
  localparam int unsigned QAw = $clog2(QDepth);

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_PARAM = 2'd1,
    CMD_ERROR = 2'd2
  } cmd_kind_e;

  // One classified request handed from front to back
  typedef struct packed {
    cmd_kind_e  kind;
    logic       fmt;
    logic [7:0] id;
    logic [7:0] len;
    logic [7:0] instr;
    logic       has_param;
    logic [7:0] param;
    logic       close;
    logic [7:0] close_byte;
  } cmd_t;

  typedef enum logic [7:0] {
    ST_SYNC1 = 8'b0000_0001,
    ST_SYNC2 = 8'b0000_0010,
    ST_ID    = 8'b0000_0100,
    ST_LEN   = 8'b0000_1000,
    ST_INSTR = 8'b0001_0000,
    ST_PARAM = 8'b0010_0000,
    ST_CLOSE = 8'b0100_0000,
    ST_ERR   = 8'b1000_0000
  } step_e;

endpackage

// ----- rtl/isf_front.sv -----
module isf_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic              frame_format_i,
  input  logic              packet_start_i,
  input  logic [7:0]        device_id_i,
  input  logic [7:0]        opcode_byte_i,
  input  logic [7:0]        param_count_i,
  input  logic [7:0]        param_byte_i,
  output logic              cmd_push_o,
  output isf_pkg::cmd_t     cmd_o
);

  logic [7:0] running_sum_q, running_sum_d;
  logic [7:0] params_left_q, params_left_d;
  logic       in_packet_q, in_packet_d;

  logic [7:0] cont_sum, cont_left;
  logic [7:0] start_len, head_sum, start_sum;
  logic       start_has_param;

  assign cont_sum        = running_sum_q + param_byte_i;
  assign cont_left       = params_left_q - 8'd1;
  assign start_len       = param_count_i + isf_pkg::LEN_OVERHEAD;
  assign head_sum        = device_id_i + start_len + opcode_byte_i;
  assign start_has_param = (param_count_i != 8'd0);
  assign start_sum       = start_has_param ? head_sum + param_byte_i : head_sum;

  always_comb begin
    running_sum_d = running_sum_q;
    params_left_d = params_left_q;
    in_packet_d   = in_packet_q;
    cmd_push_o    = 1'b0;
    cmd_o         = '0;
    cmd_o.fmt     = frame_format_i;
    cmd_o.id      = device_id_i;
    cmd_o.len     = start_len;
    cmd_o.instr   = opcode_byte_i;
    cmd_o.param   = param_byte_i;
    if (accept_i) begin
      if (!packet_start_i) begin
        // drop stray bytes outside a packet
        if (in_packet_q) begin
          cmd_push_o       = 1'b1;
          cmd_o.kind       = isf_pkg::CMD_PARAM;
          cmd_o.has_param  = 1'b1;
          cmd_o.close      = (cont_left == 8'd0);
          cmd_o.close_byte = frame_format_i ? isf_pkg::TRAILER_ALT : ~cont_sum;
          running_sum_d    = cont_sum;
          params_left_d    = cont_left;
          in_packet_d      = (cont_left != 8'd0);
        end
      end else if (param_count_i > isf_pkg::MAX_PARAMS) begin
        cmd_push_o    = 1'b1;
        cmd_o.kind    = isf_pkg::CMD_ERROR;
        running_sum_d = 8'd0;
        params_left_d = 8'd0;
        in_packet_d   = 1'b0;
      end else begin
        cmd_push_o       = 1'b1;
        cmd_o.kind       = isf_pkg::CMD_START;
        cmd_o.has_param  = start_has_param;
        cmd_o.close      = (param_count_i <= 8'd1);
        cmd_o.close_byte = frame_format_i ? isf_pkg::TRAILER_ALT : ~start_sum;
        running_sum_d    = start_sum;
        params_left_d    = start_has_param ? param_count_i - 8'd1 : 8'd0;
        in_packet_d      = (param_count_i > 8'd1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_sum_q <= 8'd0;
      params_left_q <= 8'd0;
      in_packet_q   <= 1'b0;
    end else begin
      running_sum_q <= running_sum_d;
      params_left_q <= params_left_d;
      in_packet_q   <= in_packet_d;
    end
  end

  a_open_has_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_packet_q |-> params_left_q != 8'd0)
    else $error("open packet with no parameters left");

  a_close_ends_packet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_push_o && cmd_o.close |=> !in_packet_q && params_left_q == 8'd0)
    else $error("packet still open after closing request");

  a_error_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_push_o && cmd_o.kind == isf_pkg::CMD_ERROR |=> !in_packet_q && running_sum_q == 8'd0)
    else $error("state not cleared after count error");

endmodule

// ----- rtl/isf_queue.sv -----
module isf_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  isf_pkg::cmd_t wdata_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output isf_pkg::cmd_t rdata_o
);

  isf_pkg::cmd_t             mem_q [isf_pkg::QDepth];
  logic [isf_pkg::QAw-1:0]   wr_ptr_q, rd_ptr_q;
  logic [isf_pkg::QAw:0]     count_q, count_d;
  logic                      do_push, do_pop;

  assign full_o  = (count_q == (isf_pkg::QAw+1)'(isf_pkg::QDepth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (do_push && !do_pop) count_d = count_q + 1'b1;
    else if (!do_push && do_pop) count_d = count_q - 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= wdata_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (do_pop) rd_ptr_q <= rd_ptr_q + 1'b1;
      count_q <= count_d;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= (isf_pkg::QAw+1)'(isf_pkg::QDepth))
    else $error("queue count beyond depth");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("request pushed into full queue");

  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_ptr_q - rd_ptr_q) == count_q[isf_pkg::QAw-1:0])
    else $error("queue pointers disagree with count");

endmodule

// ----- rtl/isf_back.sv -----
module isf_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cmd_empty_i,
  input  isf_pkg::cmd_t cmd_i,
  output logic          cmd_pop_o,
  input  logic          pop,
  output logic          empty,
  output logic [7:0]    out_byte_o,
  output logic          frame_end_o,
  output logic          count_error_o
);

  isf_pkg::step_e step_q, step_d, cur_step, next_step, first_step;
  logic           busy_q, busy_d;
  logic           last_step;
  logic           load;
  logic [7:0]     cur_byte;
  logic           cur_end, cur_err;

  logic           out_valid_q, out_valid_d;
  logic [7:0]     out_byte_q;
  logic           frame_end_q, count_error_q;

  always_comb begin
    unique case (cmd_i.kind)
      isf_pkg::CMD_START: first_step = isf_pkg::ST_SYNC1;
      isf_pkg::CMD_PARAM: first_step = isf_pkg::ST_PARAM;
      default:            first_step = isf_pkg::ST_ERR;
    endcase
  end

  assign cur_step = busy_q ? step_q : first_step;

  always_comb begin
    next_step = isf_pkg::ST_ERR;
    last_step = 1'b0;
    cur_byte  = 8'd0;
    cur_end   = 1'b0;
    cur_err   = 1'b0;
    unique case (cur_step)
      isf_pkg::ST_SYNC1: begin
        cur_byte  = cmd_i.fmt ? isf_pkg::SYNC_ALT : isf_pkg::SYNC_STD;
        next_step = isf_pkg::ST_SYNC2;
      end
      isf_pkg::ST_SYNC2: begin
        cur_byte  = cmd_i.fmt ? isf_pkg::SYNC_ALT : isf_pkg::SYNC_STD;
        next_step = (cmd_i.fmt == isf_pkg::FMT_ALT) ? isf_pkg::ST_LEN : isf_pkg::ST_ID;
      end
      isf_pkg::ST_ID: begin
        cur_byte  = cmd_i.id;
        next_step = isf_pkg::ST_LEN;
      end
      isf_pkg::ST_LEN: begin
        cur_byte  = cmd_i.len;
        next_step = isf_pkg::ST_INSTR;
      end
      isf_pkg::ST_INSTR: begin
        cur_byte  = cmd_i.instr;
        next_step = cmd_i.has_param ? isf_pkg::ST_PARAM : isf_pkg::ST_CLOSE;
      end
      isf_pkg::ST_PARAM: begin
        cur_byte  = cmd_i.param;
        next_step = isf_pkg::ST_CLOSE;
        last_step = !cmd_i.close;
      end
      isf_pkg::ST_CLOSE: begin
        cur_byte  = cmd_i.close_byte;
        cur_end   = 1'b1;
        last_step = 1'b1;
      end
      isf_pkg::ST_ERR: begin
        cur_byte  = isf_pkg::ERR_BYTE;
        cur_err   = 1'b1;
        last_step = 1'b1;
      end
      default: begin
        last_step = 1'b1;
      end
    endcase
  end

  // Advance when a request waits and the output slot is free or being drained this cycle
  assign load      = !cmd_empty_i && (!out_valid_q || pop);
  assign cmd_pop_o = load && last_step;

  always_comb begin
    step_d      = step_q;
    busy_d      = busy_q;
    out_valid_d = out_valid_q;
    if (pop && out_valid_q) out_valid_d = 1'b0;
    if (load) begin
      out_valid_d = 1'b1;
      busy_d      = !last_step;
      step_d      = next_step;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= isf_pkg::ST_SYNC1;
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      step_q      <= step_d;
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_byte_q    <= cur_byte;
      frame_end_q   <= cur_end;
      count_error_q <= cur_err;
    end
  end

  assign empty         = !out_valid_q;
  assign out_byte_o    = out_byte_q;
  assign frame_end_o   = frame_end_q;
  assign count_error_o = count_error_q;

  a_err_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && count_error_q |-> out_byte_q == isf_pkg::ERR_BYTE && !frame_end_q)
    else $error("malformed error result");

  a_busy_holds_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !cmd_empty_i)
    else $error("request left the queue before its last byte");

  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop && out_valid_q && cmd_empty_i |=> !out_valid_q)
    else $error("result repeated after pop");

endmodule

// ----- rtl/inverted_sum_packet_framer_core.sv -----
// Packet framer for a half-duplex actuator bus, producing the byte stream of
// command packets.
// Input side is a queue write port: an item is taken on a clock edge with
// push high and full low. The first item of a packet (packet_start_i high)
// carries id, instruction, count and the first parameter byte; every
// following item carries one parameter byte. Result side is a queue read
// port: the oldest byte sits on out_byte_o/frame_end_o/count_error_o while
// empty is low and leaves on an edge with pop high.
// frame_format is written over cfg_valid/cfg_ready/cfg_data_i (always ready).
// The user must write it only while no packet bytes are in flight; the block
// itself does not enforce this. An item's request enters the queue on the edge
// that takes it; the output register loads its first byte once the request is
// at the queue head and the output slot is free. Input runs at one item per
// cycle while the queue has room; the output moves one byte per cycle while
// pop is high, so the four-entry queue absorbs a start's five to seven bytes.
// When pop stays low the output register holds, the queue fills and full rises.
// Reset empties the queue and the output and returns to idle, format 0.
module inverted_sum_packet_framer_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic       packet_start_i,
  input  logic [7:0] device_id_i,
  input  logic [7:0] opcode_byte_i,
  input  logic [7:0] param_count_i,
  input  logic [7:0] param_byte_i,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte_o,
  output logic       frame_end_o,
  output logic       count_error_o,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_data_i
);

  logic          frame_format_q;
  logic          accept;
  logic          cmd_push, q_full, q_empty, q_pop;
  isf_pkg::cmd_t cmd_wr, cmd_rd;

  assign cfg_ready = 1'b1;
  assign full      = q_full;
  assign accept    = push && !q_full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_format_q <= isf_pkg::FMT_STD;
    end else if (cfg_valid && cfg_ready) begin
      frame_format_q <= cfg_data_i;
    end
  end

  isf_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .frame_format_i (frame_format_q),
    .packet_start_i (packet_start_i),
    .device_id_i    (device_id_i),
    .opcode_byte_i  (opcode_byte_i),
    .param_count_i  (param_count_i),
    .param_byte_i   (param_byte_i),
    .cmd_push_o     (cmd_push),
    .cmd_o          (cmd_wr)
  );

  isf_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .wdata_i (cmd_wr),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .rdata_o (cmd_rd)
  );

  isf_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_empty_i   (q_empty),
    .cmd_i         (cmd_rd),
    .cmd_pop_o     (q_pop),
    .pop           (pop),
    .empty         (empty),
    .out_byte_o    (out_byte_o),
    .frame_end_o   (frame_end_o),
    .count_error_o (count_error_o)
  );

endmodule

// ----- verif/tb_inverted_sum_packet_framer_core.sv -----
module tb_inverted_sum_packet_framer_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SETTLE = 8;

  typedef struct packed {
    logic       start;
    logic [7:0] id;
    logic [7:0] op;
    logic [7:0] cnt;
    logic [7:0] p;
  } item_t;

  typedef struct packed {
    logic [7:0] b;
    logic       fin;
    logic       err;
  } frame_byte_t;

  // Directed request: format to run under, the request, and where the bytes
  // are plain to see, the bytes typed in (first byte in the top of eb).
  typedef struct packed {
    logic        fmt;
    logic        start;
    logic [7:0]  id;
    logic [7:0]  op;
    logic [7:0]  cnt;
    logic [7:0]  p;
    logic        typed;
    logic [3:0]  n;
    logic [55:0] eb;
    logic        fin;
    logic        err;
  } dir_row_t;

  localparam dir_row_t DIRECTED [22] = '{
    '{isf_pkg::FMT_STD, 1'b0, 8'h5A, 8'hA5, 8'h03, 8'hC3, 1'b1, 4'd0, 56'h0, 1'b0, 1'b0},
    '{isf_pkg::FMT_STD, 1'b1, 8'h00, 8'h00, 8'd0, 8'hAA, 1'b1, 4'd6,
      56'hFFFF0002_00FD00, 1'b1, 1'b0},
    '{isf_pkg::FMT_STD, 1'b1, 8'hFF, 8'hFF, 8'd0, 8'h55, 1'b1, 4'd6,
      56'hFFFFFF02_FFFF00, 1'b1, 1'b0},
    '{isf_pkg::FMT_STD, 1'b1, 8'h10, 8'h20, 8'd27, 8'h33, 1'b1, 4'd1, 56'h0, 1'b0, 1'b1},
    '{isf_pkg::FMT_STD, 1'b1, 8'hEE, 8'hDD, 8'hFF, 8'hCC, 1'b1, 4'd1, 56'h0, 1'b0, 1'b1},
    '{isf_pkg::FMT_STD, 1'b0, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, 4'd0, 56'h0, 1'b0, 1'b0},
    '{isf_pkg::FMT_STD, 1'b1, 8'h01, 8'h03, 8'd1, 8'h20, 1'b0, 4'd0, 56'h0, 1'b0, 1'b0},
    '{isf_pkg::FMT_STD, 1'b1, 8'hA5, 8'h5A, 8'd3, 8'hFF, 1'b0, 4'd0, 56'h0, 1'b0, 1'b0},
    '{isf_pkg::FMT_STD, 1'b0, 8'h00, 8'h00, 8'h00, 8'h80, 1'b0, 4'd0, 56'h0, 1'b0, 1'b0},
    '{isf_pkg::FMT_STD, 1'b0, 8'hFF, 8'hFF, 8'hFF, 8'h7F, 1'b0, 4'd0, 56'h0, 1'b0, 1'b0},
    '{isf_pkg::FMT_STD, 1'b1, 8'h33, 8'h44, 8'd4, 8'h01, 1'b0, 4'd0, 56'h0, 1'b0, 1'b0},
    '{isf_pkg::FMT_STD, 1'b0, 8'h81, 8'h18, 8'h42, 8'h02, 1'b0, 4'd0, 56'h0, 1'b0, 1'b0},
    '{isf_pkg::FMT_STD, 1'b1, 8'h5C, 8'hC3, 8'd26, 8'h00, 1'b0, 4'd0, 56'h0, 1'b0, 1'b0},
    '{isf_pkg::FMT_ALT, 1'b1, 8'h12, 8'h34, 8'd0, 8'h99, 1'b1, 4'd5,
      56'hFEFE0234_FA0000, 1'b1, 1'b0},
    '{isf_pkg::FMT_ALT, 1'b1, 8'hAB, 8'hCD, 8'd27, 8'h11, 1'b1, 4'd1, 56'h0, 1'b0, 1'b1},
    '{isf_pkg::FMT_ALT, 1'b1, 8'h0F, 8'hF0, 8'd2, 8'hAA, 1'b0, 4'd0, 56'h0, 1'b0, 1'b0},
    '{isf_pkg::FMT_ALT, 1'b0, 8'h3C, 8'hC3, 8'h99, 8'h55, 1'b0, 4'd0, 56'h0, 1'b0, 1'b0},
    '{isf_pkg::FMT_ALT, 1'b1, 8'h77, 8'h88, 8'd2, 8'h01, 1'b0, 4'd0, 56'h0, 1'b0, 1'b0},
    '{isf_pkg::FMT_STD, 1'b0, 8'h66, 8'h99, 8'h0F, 8'h02, 1'b0, 4'd0, 56'h0, 1'b0, 1'b0},
    '{isf_pkg::FMT_STD, 1'b1, 8'h9A, 8'hBC, 8'd2, 8'h10, 1'b0, 4'd0, 56'h0, 1'b0, 1'b0},
    '{isf_pkg::FMT_ALT, 1'b0, 8'hC5, 8'h5C, 8'hF0, 8'h20, 1'b0, 4'd0, 56'h0, 1'b0, 1'b0},
    '{isf_pkg::FMT_ALT, 1'b1, 8'hFF, 8'h00, 8'd1, 8'hFF, 1'b0, 4'd0, 56'h0, 1'b0, 1'b0}
  };

  logic       clk_i;
  logic       rst_ni;
  logic       push;
  logic       full;
  logic       packet_start_i;
  logic [7:0] device_id_i;
  logic [7:0] opcode_byte_i;
  logic [7:0] param_count_i;
  logic [7:0] param_byte_i;
  logic       empty;
  logic       pop;
  logic [7:0] out_byte_o;
  logic       frame_end_o;
  logic       count_error_o;
  logic       cfg_valid;
  logic       cfg_ready;
  logic       cfg_data_i;

  // framer state as the predictor sees it
  logic       fmt_q;
  logic [7:0] sum_q;
  logic [7:0] left_q;
  logic       open_q;

  frame_byte_t step_bytes[$];
  frame_byte_t pending_bytes[$];

  int  mismatches;
  int  accepted_items;
  int  hold_req;
  bit  steady;

  inverted_sum_packet_framer_core DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .packet_start_i(packet_start_i),
    .device_id_i   (device_id_i),
    .opcode_byte_i (opcode_byte_i),
    .param_count_i (param_count_i),
    .param_byte_i  (param_byte_i),
    .empty         (empty),
    .pop           (pop),
    .out_byte_o    (out_byte_o),
    .frame_end_o   (frame_end_o),
    .count_error_o (count_error_o),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #400us;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic void emit(logic [7:0] b, logic fin, logic err);
    step_bytes.push_back('{b, fin, err});
  endfunction

  function automatic void close_frame();
    emit((fmt_q == isf_pkg::FMT_ALT) ? isf_pkg::TRAILER_ALT : ~sum_q, 1'b1, 1'b0);
    open_q = 1'b0;
    left_q = '0;
  endfunction

  function automatic void take_param(logic [7:0] p);
    sum_q = sum_q + p;
    left_q = left_q - 8'd1;
    emit(p, 1'b0, 1'b0);
    if (left_q == 0) close_frame();
  endfunction

  function automatic void frame_predict(item_t it);
    logic [7:0] len;
    step_bytes.delete();
    if (!it.start) begin
      if (open_q) take_param(it.p);
      return;
    end
    // count too large: single error byte, drop the packet
    if (it.cnt > isf_pkg::MAX_PARAMS) begin
      open_q = 1'b0;
      left_q = '0;
      sum_q = '0;
      emit(isf_pkg::ERR_BYTE, 1'b0, 1'b1);
      return;
    end
    len = it.cnt + isf_pkg::LEN_OVERHEAD;
    if (fmt_q == isf_pkg::FMT_ALT) begin
      emit(isf_pkg::SYNC_ALT, 1'b0, 1'b0);
      emit(isf_pkg::SYNC_ALT, 1'b0, 1'b0);
    end else begin
      emit(isf_pkg::SYNC_STD, 1'b0, 1'b0);
      emit(isf_pkg::SYNC_STD, 1'b0, 1'b0);
      emit(it.id, 1'b0, 1'b0);
    end
    emit(len, 1'b0, 1'b0);
    emit(it.op, 1'b0, 1'b0);
    sum_q = it.id + len + it.op;
    left_q = it.cnt;
    open_q = 1'b1;
    if (it.cnt == 0) close_frame();
    else take_param(it.p);
  endfunction

  task automatic flag_mismatch(input string msg);
    mismatches++;
    $display("%0t mismatch: %s", $time, msg);
  endtask

  task automatic check_byte();
    frame_byte_t want;
    if (pending_bytes.size() == 0) begin
      flag_mismatch($sformatf("unexpected byte %02h", out_byte_o));
      return;
    end
    want = pending_bytes.pop_front();
    if (out_byte_o !== want.b)
      flag_mismatch($sformatf("out_byte %02h, want %02h", out_byte_o, want.b));
    if (frame_end_o !== want.fin)
      flag_mismatch($sformatf("frame_end %b, want %b on byte %02h", frame_end_o, want.fin,
                              want.b));
    if (count_error_o !== want.err)
      flag_mismatch($sformatf("count_error %b, want %b on byte %02h", count_error_o,
                              want.err, want.b));
  endtask

  // receiver: random pops, long hold-offs on request
  initial begin
    int hold_left;
    hold_left = 0;
    pop <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && pop && !empty) check_byte();
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else if (steady) begin
        pop <= 1'b1;
      end else begin
        pop <= ($urandom_range(99) >= 18);
      end
    end
  end

  task automatic send_item(input item_t it, input bit from_model);
    if (!steady) begin
      while ($urandom_range(99) < 18) begin
        push <= 1'b0;
        @(posedge clk_i);
      end
    end
    push <= 1'b1;
    packet_start_i <= it.start;
    device_id_i <= it.id;
    opcode_byte_i <= it.op;
    param_count_i <= it.cnt;
    param_byte_i <= it.p;
    do @(posedge clk_i); while (full !== 1'b0);
    if (it.start || open_q) accepted_items++;
    frame_predict(it);
    if (from_model) begin
      foreach (step_bytes[j]) pending_bytes.push_back(step_bytes[j]);
    end
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic set_format(input logic fmt);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data_i <= fmt;
    do @(posedge clk_i); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
    fmt_q = fmt;
  endtask

  // mostly whole packets; some stray bytes, oversize counts and cut-off packets
  task automatic send_packet();
    item_t it;
    int unsigned kind;
    int unsigned cut;
    kind = $urandom_range(99);
    it.start = 1'b1;
    it.id = 8'($urandom);
    it.op = 8'($urandom);
    it.p = 8'($urandom);
    if (kind < 8) begin
      it.start = 1'b0;
      it.cnt = 8'($urandom);
      send_item(it, 1'b1);
      return;
    end
    if (kind < 16) begin
      it.cnt = 8'($urandom_range(255, isf_pkg::MaxParams + 1));
      send_item(it, 1'b1);
      return;
    end
    it.cnt = (kind < 28) ? 8'($urandom_range(isf_pkg::MaxParams, 9))
                         : 8'($urandom_range(8, 0));
    cut = ($urandom_range(99) < 6) ? $urandom_range(it.cnt) : it.cnt;
    send_item(it, 1'b1);
    for (int i = 1; i < cut; i++) begin
      it.start = 1'b0;
      it.id = 8'($urandom);
      it.op = 8'($urandom);
      it.cnt = 8'($urandom);
      it.p = 8'($urandom);
      send_item(it, 1'b1);
    end
  endtask

  initial begin
    dir_row_t row;
    int base;
    mismatches = 0;
    accepted_items = 0;
    hold_req = 0;
    steady = 1'b0;
    fmt_q = isf_pkg::FMT_STD;
    sum_q = '0;
    left_q = '0;
    open_q = 1'b0;
    rst_ni <= 1'b0;
    push <= 1'b0;
    packet_start_i <= 1'b0;
    device_id_i <= '0;
    opcode_byte_i <= '0;
    param_count_i <= '0;
    param_byte_i <= '0;
    cfg_valid <= 1'b0;
    cfg_data_i <= 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (DIRECTED[i]) begin
      row = DIRECTED[i];
      if (row.fmt !== fmt_q) set_format(row.fmt);
      send_item({row.start, row.id, row.op, row.cnt, row.p}, !row.typed);
      if (row.typed) begin
        for (int k = 0; k < row.n; k++)
          pending_bytes.push_back('{row.eb[55 - 8*k -: 8], row.fin && (k == row.n - 1),
                                    row.err && (k == 0)});
      end
    end

    for (int ph = 0; ph < 4; ph++) begin
      set_format(ph[0] ? isf_pkg::FMT_ALT : isf_pkg::FMT_STD);
      steady = (ph == 1);
      // hold the receiver off so the request queue fills and full rises
      if (ph == 2) hold_req = 90;
      base = accepted_items;
      while (accepted_items - base < 33) send_packet();
    end
    steady = 1'b0;

    wait_drained();
    repeat (SETTLE) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
